@@ design/one_at_a_time_bucket_hash_defines.svh @@
// Assertion macros used by the checker file of the bucket hash.
`ifndef ONE_AT_A_TIME_BUCKET_HASH_DEFINES_SVH
`define ONE_AT_A_TIME_BUCKET_HASH_DEFINES_SVH

// Same-cycle implication, disabled while the given reset is high.
`define OAAT_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while the given reset is high.
`define OAAT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

@@ design/oaat_pkg.sv @@
`timescale 1ns / 1ps
package oaat_pkg;

   localparam int HASH_WIDTH   = 64;
   localparam int COUNT_WIDTH  = 32;
   localparam int BYTE_WIDTH   = 8;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_WIDTH   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_WIDTH   = $clog2(QUEUE_DEPTH + 1);
   localparam int STEP_WIDTH   = $clog2(HASH_WIDTH);

   localparam int MIX_ADD_SHIFT = 10;
   localparam int MIX_XOR_SHIFT = 6;
   localparam int FIN_ADD_SHIFT_A = 3;
   localparam int FIN_XOR_SHIFT = 11;
   localparam int FIN_ADD_SHIFT_B = 15;

   localparam logic [COUNT_WIDTH-1:0] BUCKET_COUNT_RESET = COUNT_WIDTH'(1024);

   typedef logic [HASH_WIDTH-1:0] hash_type;

   typedef struct packed {
      logic     valid;
      hash_type hash;
   } hash_item_type;

   function automatic hash_type mix_byte(hash_type h, logic [BYTE_WIDTH-1:0] b);
      hash_type s;
      hash_type t;
      s = h + HASH_WIDTH'(b);
      t = s + (s << MIX_ADD_SHIFT);
      return t ^ (t >> MIX_XOR_SHIFT);
   endfunction

endpackage

@@ design/oaat_front.sv @@
`timescale 1ns / 1ps
module oaat_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_key_byte,
   input  logic                          req_has_byte,
   input  logic                          req_last,
   output oaat_pkg::hash_item_type       push,
   input  logic                          push_ready
);
   import oaat_pkg::*;

   hash_type running_ff;
   hash_type running_in;
   hash_type mixed;
   logic     accept;

   assign req_ready = push_ready;
   assign accept    = req_valid && push_ready;
   assign mixed     = req_has_byte ? mix_byte(running_ff, req_key_byte) : running_ff;

   always_comb begin
      running_in = running_ff;
      push.valid = 1'b0;
      push.hash  = mixed;
      if (accept) begin
         if (req_last) begin
            push.valid = 1'b1;
            running_in = '0;
         end else begin
            running_in = mixed;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff <= '0;
      end else begin
         running_ff <= running_in;
      end
   end

endmodule

@@ design/oaat_queue.sv @@
`timescale 1ns / 1ps
module oaat_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  oaat_pkg::hash_item_type       push,
   output logic                          push_ready,
   output oaat_pkg::hash_item_type       pop,
   input  logic                          pop_ready
);
   import oaat_pkg::*;

   hash_type                entry_ff [QUEUE_DEPTH];
   logic [QPTR_WIDTH-1:0]   wr_ptr_ff;
   logic [QPTR_WIDTH-1:0]   wr_ptr_in;
   logic [QPTR_WIDTH-1:0]   rd_ptr_ff;
   logic [QPTR_WIDTH-1:0]   rd_ptr_in;
   logic [QCNT_WIDTH-1:0]   count_ff;
   logic [QCNT_WIDTH-1:0]   count_in;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != QCNT_WIDTH'(QUEUE_DEPTH));
   assign pop.valid  = (count_ff != '0);
   assign pop.hash   = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop.valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_WIDTH'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.hash;
      end
   end

endmodule

@@ design/oaat_back.sv @@
`timescale 1ns / 1ps
module oaat_back (
   input  logic                          clock,
   input  logic                          reset,
   input  oaat_pkg::hash_item_type       pop,
   output logic                          pop_ready,
   input  logic                          csr_wr_en,
   input  logic [31:0]                   csr_wr_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [31:0]                   rsp_bucket_index,
   output logic [63:0]                   rsp_hash_value
);
   import oaat_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE    = 6'b000001,
      ST_FIN_A   = 6'b000010,
      ST_FIN_B   = 6'b000100,
      ST_FIN_C   = 6'b001000,
      ST_DIVIDE  = 6'b010000,
      ST_DELIVER = 6'b100000
   } back_state_type;

   back_state_type           state_ff;
   back_state_type           state_in;
   hash_type                 h_ff;
   hash_type                 h_in;
   hash_type                 dvd_ff;
   hash_type                 dvd_in;
   hash_type                 fin;
   logic [COUNT_WIDTH-1:0]   rem_ff;
   logic [COUNT_WIDTH-1:0]   rem_in;
   logic [STEP_WIDTH-1:0]    step_ff;
   logic [STEP_WIDTH-1:0]    step_in;
   logic [COUNT_WIDTH-1:0]   bucket_count_ff;
   logic [COUNT_WIDTH-1:0]   bucket_count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   logic [31:0]              rsp_index_ff;
   logic [31:0]              rsp_index_in;
   logic [63:0]              rsp_hash_ff;
   logic [63:0]              rsp_hash_in;
   logic [COUNT_WIDTH:0]     shifted;
   logic [COUNT_WIDTH:0]     diff;
   logic                     fits;
   logic                     out_free;

   assign pop_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_bucket_index = rsp_index_ff;
   assign rsp_hash_value   = rsp_hash_ff;

   assign shifted  = {rem_ff, dvd_ff[HASH_WIDTH-1]};
   assign fits     = (shifted >= {1'b0, bucket_count_ff});
   assign diff     = shifted - {1'b0, bucket_count_ff};
   assign fin      = h_ff + (h_ff << FIN_ADD_SHIFT_B);
   assign out_free = !rsp_valid_ff || rsp_ready;

   assign bucket_count_in = csr_wr_en ? csr_wr_data : bucket_count_ff;

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (pop.valid) begin
               h_in     = pop.hash;
               state_in = ST_FIN_A;
            end
         end
         ST_FIN_A: begin
            h_in     = h_ff + (h_ff << FIN_ADD_SHIFT_A);
            state_in = ST_FIN_B;
         end
         ST_FIN_B: begin
            h_in     = h_ff ^ (h_ff >> FIN_XOR_SHIFT);
            state_in = ST_FIN_C;
         end
         ST_FIN_C: begin
            h_in     = fin;
            dvd_in   = fin;
            rem_in   = '0;
            step_in  = STEP_WIDTH'(HASH_WIDTH - 1);
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            rem_in = fits ? diff[COUNT_WIDTH-1:0] : shifted[COUNT_WIDTH-1:0];
            dvd_in = dvd_ff << 1;
            if (step_ff == '0) begin
               state_in = ST_DELIVER;
            end else begin
               step_in = step_ff - 1'b1;
            end
         end
         ST_DELIVER: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_index_in = (bucket_count_ff == '0) ? '0 : rem_ff;
               rsp_hash_in  = 64'(h_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         bucket_count_ff <= BUCKET_COUNT_RESET;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         bucket_count_ff <= bucket_count_in;
      end
   end

   always_ff @(posedge clock) begin
      h_ff         <= h_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      step_ff      <= step_in;
      rsp_index_ff <= rsp_index_in;
      rsp_hash_ff  <= rsp_hash_in;
   end

endmodule

@@ design/one_at_a_time_bucket_hash.sv @@
`timescale 1ns / 1ps
// Channel    Ports                                          Accepted when
// request    req_key_byte, req_has_byte, req_last           req_valid && req_ready
// response   rsp_bucket_index, rsp_hash_value               rsp_valid && rsp_ready
// csr        csr_wr_data (bucket count)                     csr_wr_en
//
// A key byte is mixed into the running hash register; bytes stream at one per cycle
// while the queue has room. The back end puts each key through three finalize steps,
// a restoring division that takes in one dividend bit per cycle, and the hand-off.
// A two-entry queue holds finished keys, so the front stalls only when it is full.
// Reset is synchronous; it clears the running hash, the queue and the response valid.
module one_at_a_time_bucket_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_key_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_bucket_index,
   output logic [63:0] rsp_hash_value,
   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import oaat_pkg::*;

   hash_item_type push;
   hash_item_type pop;
   logic          push_ready;
   logic          pop_ready;

   oaat_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_key_byte (req_key_byte),
      .req_has_byte (req_has_byte),
      .req_last     (req_last),
      .push         (push),
      .push_ready   (push_ready)
   );

   oaat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop        (pop),
      .pop_ready  (pop_ready)
   );

   oaat_back u_back (
      .clock            (clock),
      .reset            (reset),
      .pop              (pop),
      .pop_ready        (pop_ready),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_hash_value   (rsp_hash_value)
   );

endmodule

@@ design/oaat_checker.sv @@
`timescale 1ns / 1ps
`include "one_at_a_time_bucket_hash_defines.svh"
module oaat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_bucket_index,
   input logic [63:0] rsp_hash_value,
   input logic        csr_wr_en,
   input logic [31:0] csr_wr_data
);
   import oaat_pkg::*;

   logic [COUNT_WIDTH-1:0] shadow_count_ff;
   logic                   last_accept;
   logic                   index_ok;

   assign last_accept = req_valid && req_ready && req_last;
   assign index_ok    = (shadow_count_ff == '0) ? (rsp_bucket_index == '0)
                                                : (rsp_bucket_index < shadow_count_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         shadow_count_ff <= BUCKET_COUNT_RESET;
      end else if (csr_wr_en) begin
         shadow_count_ff <= csr_wr_data;
      end
   end

   `OAAT_ASSERT_NEXT(a_reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)
   `OAAT_ASSERT_SAME(a_index_in_range, clock, reset, rsp_valid, index_ok)
   `OAAT_ASSERT_SAME(a_no_bypass, clock, reset, $rose(rsp_valid), !$past(last_accept))
   `OAAT_ASSERT_NEXT(a_rsp_held, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_hash_value) && $stable(rsp_bucket_index))

endmodule

bind one_at_a_time_bucket_hash oaat_checker u_oaat_checker (.*);
